// ----- hw/rtl/ospm_pkg.sv -----
// ----------------------------------------------------------------------------
// ospm_pkg
// Shared constants, types and carrier helpers for the OFDM pilot mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ospm_pkg;

    localparam int unsigned IDX_W           = 9;
    localparam int unsigned SAMPLE_W        = 16;
    localparam int unsigned AMP_W           = 15;
    localparam int unsigned CNT_W           = 9;
    localparam int unsigned OFF_W           = 5;
    localparam int unsigned NP_W            = 10;
    localparam int unsigned PILOT_PERIOD    = 22;
    localparam int unsigned PILOT_STEP      = 3;
    localparam int unsigned DATA_PER_SYMBOL = 336;
    localparam int unsigned QDEPTH          = 4;
    localparam int unsigned QPTR_W          = $clog2(QDEPTH);
    localparam int unsigned QCNT_W          = QPTR_W + 1;

    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [AMP_W-1:0]           amp_t;

    localparam idx_t FIRST_USED = 9'd79;
    localparam idx_t LAST_USED  = 9'd433;
    localparam idx_t DC_LO      = 9'd255;
    localparam idx_t DC_HI      = 9'd257;
    localparam amp_t AMP_RESET  = 15'd16384;

    typedef struct packed {
        logic    lead;
        idx_t    lead_idx;
        idx_t    data_idx;
        sample_t re;
        sample_t im;
        logic    trail;
        idx_t    trail_idx;
        logic    sym_end;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [1:0] {
        ST_LEAD,
        ST_DATA,
        ST_TRAIL
    } stage_t;

    function automatic logic is_dc(input idx_t p);
        return (p >= DC_LO) && (p <= DC_HI);
    endfunction

    function automatic logic is_usable(input idx_t p);
        return (p >= FIRST_USED) && (p <= LAST_USED) && !is_dc(p);
    endfunction

    function automatic idx_t next_carrier(input idx_t p);
        idx_t p1;
        p1 = p + idx_t'(1);
        if (is_dc(p1))
        begin
            p1 = DC_HI + idx_t'(1);
        end
        return p1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ospm_front.sv -----
// ----------------------------------------------------------------------------
// ospm_front
// Accepts data symbols, tracks carrier position and pilot grid, and queues
// one descriptor per item (leading pilot, data carrier, trailing pilot).
// ----------------------------------------------------------------------------
`default_nettype none

module ospm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ospm_pkg::sample_t data_real,
    input  wire ospm_pkg::sample_t data_imag,
    input  wire ospm_pkg::qstat_t q_stat,
    output logic                  push,
    output ospm_pkg::qentry_t     entry
);
    import ospm_pkg::*;

    idx_t             pos_reg, pos_next;
    logic [NP_W-1:0]  np_reg, np_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             lead, last, trail;
    idx_t             p1, p2;
    logic [NP_W-1:0]  np1, np2;
    logic [OFF_W-1:0] off_adv, off_sym;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        lead    = ({1'b0, pos_reg} == np_reg) && is_usable(pos_reg);
        p1      = lead ? next_carrier(pos_reg) : pos_reg;
        np1     = lead ? np_reg + NP_W'(PILOT_PERIOD) : np_reg;
        p2      = next_carrier(p1);
        np2     = (np1 < {1'b0, p2}) ? np1 + NP_W'(PILOT_PERIOD) : np1;
        last    = (count_reg == CNT_W'(DATA_PER_SYMBOL - 1));
        trail   = last && (np2 == {1'b0, p2}) && is_usable(p2);
        off_adv = off_reg + OFF_W'(PILOT_STEP);
        off_sym = (off_adv >= OFF_W'(PILOT_PERIOD)) ? off_adv - OFF_W'(PILOT_PERIOD) : off_adv;
    end

    always_comb
    begin
        entry.lead      = lead;
        entry.lead_idx  = pos_reg;
        entry.data_idx  = p1;
        entry.re        = data_real;
        entry.im        = data_imag;
        entry.trail     = trail;
        entry.trail_idx = p2;
        entry.sym_end   = last;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        np_next    = np_reg;
        off_next   = off_reg;
        count_next = count_reg;
        if (push)
        begin
            if (last)
            begin
                pos_next   = FIRST_USED;
                np_next    = NP_W'(FIRST_USED) + NP_W'(off_sym);
                off_next   = off_sym;
                count_next = '0;
            end
            else
            begin
                pos_next   = p2;
                np_next    = np2;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= FIRST_USED;
            np_reg    <= NP_W'(FIRST_USED);
            off_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            np_reg    <= np_next;
            off_reg   <= off_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ospm_queue.sv -----
// ----------------------------------------------------------------------------
// ospm_queue
// Small register FIFO of item descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ospm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ospm_pkg::qentry_t entry,
    input  wire logic              pop,
    output ospm_pkg::qentry_t      head,
    output ospm_pkg::qstat_t       q_stat
);
    import ospm_pkg::*;

    qentry_t           entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ospm_back.sv -----
// ----------------------------------------------------------------------------
// ospm_back
// Walks each queued descriptor and drives one carrier per transfer into a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ospm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ospm_pkg::amp_t    amp,
    input  wire ospm_pkg::qstat_t  q_stat,
    input  wire ospm_pkg::qentry_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ospm_pkg::idx_t         carrier_index,
    output ospm_pkg::sample_t      carrier_real,
    output ospm_pkg::sample_t      carrier_imag,
    output logic                   is_pilot,
    output logic                   symbol_end
);
    import ospm_pkg::*;

    stage_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    idx_t    idx_reg;
    sample_t re_reg, im_reg;
    logic    pil_reg, end_reg;

    logic    load, done;
    idx_t    r_idx;
    sample_t r_re, r_im, pilot_re;
    logic    r_pil, r_end;

    assign load     = !q_stat.empty && (!out_valid_reg || out_ready);
    assign pilot_re = sample_t'({1'b0, amp});

    always_comb
    begin
        r_idx = head.data_idx;
        r_re  = head.re;
        r_im  = head.im;
        r_pil = 1'b0;
        r_end = head.sym_end && !head.trail;
        done  = !head.trail;
        unique case (state_reg)
            ST_LEAD:
            begin
                if (head.lead)
                begin
                    r_idx = head.lead_idx;
                    r_re  = pilot_re;
                    r_im  = '0;
                    r_pil = 1'b1;
                    r_end = 1'b0;
                    done  = 1'b0;
                end
            end
            ST_DATA:
            begin
                r_pil = 1'b0;
            end
            ST_TRAIL:
            begin
                r_idx = head.trail_idx;
                r_re  = pilot_re;
                r_im  = '0;
                r_pil = 1'b1;
                r_end = 1'b1;
                done  = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        pop = load && done;
    end

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            unique case (state_reg)
                ST_LEAD:
                begin
                    if (head.lead)
                        state_next = ST_DATA;
                    else if (head.trail)
                        state_next = ST_TRAIL;
                    else
                        state_next = ST_LEAD;
                end
                ST_DATA:  state_next = head.trail ? ST_TRAIL : ST_LEAD;
                ST_TRAIL: state_next = ST_LEAD;
                default:  state_next = ST_LEAD;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg <= r_idx;
            re_reg  <= r_re;
            im_reg  <= r_im;
            pil_reg <= r_pil;
            end_reg <= r_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign carrier_index = idx_reg;
    assign carrier_real  = re_reg;
    assign carrier_imag  = im_reg;
    assign is_pilot      = pil_reg;
    assign symbol_end    = end_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ofdm_subcarrier_pilot_mapper.sv -----
// ----------------------------------------------------------------------------
// ofdm_subcarrier_pilot_mapper
// Maps data symbols onto a 512-carrier OFDM symbol with rotating pilots.
// The first carrier of an item is written to the descriptor queue, then to the output register.
// Throughput: one carrier per cycle from the single output register while out_ready is
// high and the queue is not empty; an item gives 1 to 3 carriers, 352 per 336 items.
// Input takes one item per cycle while the four-entry descriptor queue has room.
// Reset: pilot amplitude 16384, pilot phase 0, carrier 79; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ofdm_subcarrier_pilot_mapper (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire ospm_pkg::amp_t    pilot_amplitude,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ospm_pkg::sample_t data_real,
    input  wire ospm_pkg::sample_t data_imag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ospm_pkg::idx_t         carrier_index,
    output ospm_pkg::sample_t      carrier_real,
    output ospm_pkg::sample_t      carrier_imag,
    output logic                   is_pilot,
    output logic                   symbol_end
);
    import ospm_pkg::*;

    amp_t    amp_reg, amp_next;
    qentry_t entry, head;
    qstat_t  q_stat;
    logic    push, pop;

    assign cfg_ready = 1'b1;
    assign amp_next  = (cfg_valid && cfg_ready) ? pilot_amplitude : amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            amp_reg <= AMP_RESET;
        else
            amp_reg <= amp_next;
    end

    ospm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_real (data_real),
        .data_imag (data_imag),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (entry)
    );

    ospm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .entry  (entry),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    ospm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .amp           (amp_reg),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .carrier_index (carrier_index),
        .carrier_real  (carrier_real),
        .carrier_imag  (carrier_imag),
        .is_pilot      (is_pilot),
        .symbol_end    (symbol_end)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ospm_checker.sv -----
// ----------------------------------------------------------------------------
// ospm_checker
// Port-level checks on the mapper output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ospm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ospm_pkg::idx_t    carrier_index,
    input wire ospm_pkg::sample_t carrier_real,
    input wire ospm_pkg::sample_t carrier_imag,
    input wire logic              is_pilot,
    input wire logic              symbol_end
);
    import ospm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(carrier_index)
            && $stable(carrier_real) && $stable(carrier_imag)
            && $stable(is_pilot) && $stable(symbol_end))
        else $error("output changed while stalled");

    a_pilot_imag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pilot |-> carrier_imag == '0)
        else $error("pilot with nonzero quadrature part");

    a_pilot_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pilot |-> !carrier_real[SAMPLE_W-1])
        else $error("pilot with negative amplitude");

    a_index_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> carrier_index >= FIRST_USED && carrier_index <= LAST_USED
            && (carrier_index < DC_LO || carrier_index > DC_HI))
        else $error("transfer on a null carrier");

endmodule

bind ofdm_subcarrier_pilot_mapper ospm_checker u_ospm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .carrier_index (carrier_index),
    .carrier_real  (carrier_real),
    .carrier_imag  (carrier_imag),
    .is_pilot      (is_pilot),
    .symbol_end    (symbol_end)
);

`default_nettype wire

// ----- verif/tb_ofdm_subcarrier_pilot_mapper.sv -----
// ----------------------------------------------------------------------------
// tb_ofdm_subcarrier_pilot_mapper
// Self-checking bench for the OFDM subcarrier mapper with rotating pilots.
// A shadow model of the carrier walk (guard and DC nulls, pilot comb that
// rotates with the symbol count, trailing pilot, end-of-symbol flag) builds
// the expected carrier stream. A monitor compares every output transfer with
// it. Directed corner data comes first, then random data with random gaps on
// both sides, and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ofdm_subcarrier_pilot_mapper;

    timeunit 1ns;
    timeprecision 1ps;

    import ospm_pkg::*;

    typedef struct packed {
        idx_t    index;
        sample_t re;
        sample_t im;
        logic    pilot;
        logic    last;
    } carrier_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_valid;
    logic    cfg_ready;
    amp_t    pilot_amplitude;
    logic    in_valid;
    logic    in_ready;
    sample_t data_real;
    sample_t data_imag;
    logic    out_valid;
    logic    out_ready;
    idx_t    carrier_index;
    sample_t carrier_real;
    sample_t carrier_imag;
    logic    is_pilot;
    logic    symbol_end;

    carrier_t    expected_carriers [$];
    int unsigned sym_phase;
    int unsigned data_placed;
    idx_t        next_pos;
    amp_t        amp_now;
    int          mismatches;
    bit          send_burst;
    bit          rx_burst;
    int          rx_hold;

    sample_t corner_vals [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                 16'h0001, 16'h5555, 16'hAAAA, 16'h0000};

    ofdm_subcarrier_pilot_mapper dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .pilot_amplitude (pilot_amplitude),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_real       (data_real),
        .data_imag       (data_imag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .carrier_index   (carrier_index),
        .carrier_real    (carrier_real),
        .carrier_imag    (carrier_imag),
        .is_pilot        (is_pilot),
        .symbol_end      (symbol_end)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic sample_t random_sample();
        if ($urandom_range(0, 7) == 0)
        begin
            return corner_vals[$urandom_range(0, 7)];
        end
        return sample_t'($urandom);
    endfunction

    function automatic void log_mismatch(input string msg);
        if (mismatches < 10)
        begin
            $display("mismatch: %s", msg);
        end
        mismatches++;
    endfunction

    function automatic void add_expected(input carrier_t c);
        expected_carriers = {expected_carriers, c};
    endfunction

    function automatic bit pilot_at(input idx_t p);
        int unsigned offset;
        int unsigned span;
        if (p < FIRST_USED || p > LAST_USED || (p >= DC_LO && p <= DC_HI))
        begin
            return 1'b0;
        end
        offset = (PILOT_STEP * sym_phase) % PILOT_PERIOD;
        span   = 32'(p - FIRST_USED);
        return (span >= offset) && (((span - offset) % PILOT_PERIOD) == 0);
    endfunction

    function automatic idx_t step_carrier(input idx_t p);
        idx_t q;
        q = p + idx_t'(1);
        if (q >= DC_LO && q <= DC_HI)
        begin
            q = DC_HI + idx_t'(1);
        end
        return q;
    endfunction

    function automatic void map_symbol(input sample_t re, input sample_t im);
        carrier_t pilot_c;
        carrier_t data_c;
        pilot_c.index = '0;
        pilot_c.re    = sample_t'({1'b0, amp_now});
        pilot_c.im    = '0;
        pilot_c.pilot = 1'b1;
        pilot_c.last  = 1'b0;
        if (pilot_at(next_pos))
        begin
            pilot_c.index = next_pos;
            add_expected(pilot_c);
            next_pos = step_carrier(next_pos);
        end
        data_c.index = next_pos;
        data_c.re    = re;
        data_c.im    = im;
        data_c.pilot = 1'b0;
        data_c.last  = 1'b0;
        data_placed++;
        next_pos = step_carrier(next_pos);
        if (data_placed >= DATA_PER_SYMBOL)
        begin
            if (pilot_at(next_pos))
            begin
                add_expected(data_c);
                pilot_c.index = next_pos;
                pilot_c.last  = 1'b1;
                add_expected(pilot_c);
            end
            else
            begin
                data_c.last = 1'b1;
                add_expected(data_c);
            end
            sym_phase   = (sym_phase + 1) % PILOT_PERIOD;
            data_placed = 0;
            next_pos    = FIRST_USED;
        end
        else
        begin
            add_expected(data_c);
        end
    endfunction

    task automatic send_symbol(input sample_t re, input sample_t im);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_real <= re;
        data_imag <= im;
        do @(posedge clk); while (in_ready !== 1'b1);
        map_symbol(re, im);
        @(negedge clk);
    endtask

    task automatic set_pilot_amplitude(input amp_t value);
        cfg_valid       <= 1'b1;
        pilot_amplitude <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        amp_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_carriers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic test_reset_amplitude();
        for (int i = 0; i < 6; i++)
        begin
            send_symbol(corner_vals[i % 8], corner_vals[(i + 3) % 8]);
        end
        drain_results();
    endtask

    task automatic test_full_scale_pilot();
        set_pilot_amplitude('1);
        for (int i = 0; i < 16; i++)
        begin
            send_symbol(corner_vals[(i + 6) % 8], corner_vals[(i + 1) % 8]);
        end
        drain_results();
    endtask

    task automatic test_random_stream();
        set_pilot_amplitude('0);
        repeat (108)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_burst = ~send_burst;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                rx_burst = ~rx_burst;
            end
            send_symbol(random_sample(), random_sample());
        end
        drain_results();
        send_burst = 1'b0;
        rx_burst   = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_pilot_amplitude(amp_t'($urandom));
        send_burst = 1'b1;
        rx_hold    = 60;
        repeat (30)
        begin
            send_symbol(random_sample(), random_sample());
        end
        drain_results();
        send_burst = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_carriers
        carrier_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_carriers.size() == 0)
            begin
                log_mismatch($sformatf("unexpected carrier idx=%0d re=%0d im=%0d",
                                       carrier_index, carrier_real, carrier_imag));
            end
            else
            begin
                want = expected_carriers.pop_front();
                if (carrier_index !== want.index || carrier_real !== want.re ||
                    carrier_imag !== want.im || is_pilot !== want.pilot ||
                    symbol_end !== want.last)
                begin
                    log_mismatch({
                        $sformatf("exp idx=%0d re=%0d im=%0d pilot=%0b end=%0b, ",
                                  want.index, want.re, want.im, want.pilot, want.last),
                        $sformatf("got idx=%0d re=%0d im=%0d pilot=%0b end=%0b",
                                  carrier_index, carrier_real, carrier_imag, is_pilot,
                                  symbol_end)});
                end
            end
        end
    end

    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(rx_burst);
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        #3_000_000;
        $display("[ofdm_subcarrier_pilot_mapper] ERROR");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        pilot_amplitude = AMP_RESET;
        in_valid        = 1'b0;
        data_real       = '0;
        data_imag       = '0;
        sym_phase       = 0;
        data_placed     = 0;
        next_pos        = FIRST_USED;
        amp_now         = AMP_RESET;
        mismatches      = 0;
        send_burst      = 1'b0;
        rx_burst        = 1'b0;
        rx_hold         = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_amplitude();
        test_full_scale_pilot();
        test_random_stream();
        test_output_backpressure();

        if (expected_carriers.size() != 0)
        begin
            log_mismatch($sformatf("%0d carriers never arrived", expected_carriers.size()));
        end
        if (mismatches == 0)
        begin
            $display("[ofdm_subcarrier_pilot_mapper] OK");
        end
        else
        begin
            $display("[ofdm_subcarrier_pilot_mapper] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/ospm_pkg.sv
hw/rtl/ospm_front.sv
hw/rtl/ospm_queue.sv
hw/rtl/ospm_back.sv
hw/rtl/ofdm_subcarrier_pilot_mapper.sv
hw/rtl/ospm_checker.sv
verif/tb_ofdm_subcarrier_pilot_mapper.sv
